// ===== rtl/core/sdi_pkg.sv =====
// Shared types, constants and time helpers for the scheduled dimming interpolator.
package sdi_pkg;

    typedef struct packed {
        logic       req_type;
        logic [2:0] point_index;
        logic       point_present;
        logic [4:0] point_hour;
        logic [5:0] point_minute;
        logic [7:0] point_level;
        logic [4:0] query_hour;
        logic [5:0] query_minute;
        logic [5:0] query_second;
    } sdi_item_t;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] duty;
        logic       supply_off;
    } sdi_result_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] level;
    } sdi_point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_ADJ,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_CLAMP,
        ST_LVL,
        ST_DMUL
    } sdi_state_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_LEVEL = 1'b0;

    localparam logic [7:0] MAX_LEVEL_RESET = 8'hFF;
    localparam int HALF_W = 16;
    localparam int SEC_W  = 17;
    localparam int WRAP_W = 18;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 8;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIV_D_W = 17;
    localparam logic [WRAP_W-1:0] DAY_SECONDS = WRAP_W'(86400);
    localparam logic [7:0] LEVEL_TOP = 8'hFF;

    function automatic logic [HALF_W-1:0] sdi_half_of(input logic [4:0] h, input logic [5:0] m);
        return HALF_W'(h * 1800 + m * 30);
    endfunction

    function automatic logic [SEC_W-1:0] sdi_sec_of(input logic [4:0] h, input logic [5:0] m);
        return SEC_W'(h * 3600 + m * 60);
    endfunction

endpackage

// ===== rtl/core/sdi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sdi_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sdi_serial_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module sdi_serial_mul #(
    parameter int A_W = 17,
    parameter int B_W = 8,
    localparam int P_W = A_W + B_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = P_W'(a);
            b_next   = b;
            acc_next = '0;
            cnt_next = CNT_W'(B_W);
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next    = a_reg << 1;
            b_next    = b_reg >> 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/sdi_serial_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
module sdi_serial_div #(
    parameter int N_W = 25,
    parameter int D_W = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg, q_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [D_W:0]     part;
    logic             qbit;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        part      = {rem_reg, q_reg[N_W-1]};
        qbit      = (part >= {1'b0, dvs_reg});
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(N_W);
        end
        else if (cnt_reg != '0)
        begin
            if (qbit)
            begin
                rem_next = D_W'(part - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = part[D_W-1:0];
            end
            q_next    = {q_reg[N_W-2:0], qbit};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/core/scheduled_dimming_interpolator.sv =====
// Scheduled dimming interpolator top level: point table, scan sequencer and serial math.
//
// Usage:
//   Command channel: drive item and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. Each transaction gives exactly one result
//   on result, marked by a one-cycle done pulse; the receiver cannot stall it.
//   Write transactions (req_type 0) store one schedule point and return a registered
//   result of zeros; busy stays low, so a new transaction may follow in the next cycle.
//   A query on an empty table (slot 0 absent) also returns straight from idle, with
//   supply_off set. Other queries scan the table one slot per cycle through the point
//   RAM until a slot brackets the query time, run the time arithmetic (ST_PREP, ST_ADJ,
//   ST_DIFF), then the serial multiplier, the serial divider, a clamp step and a second
//   serial multiply for the duty value; the result is then registered. When the two
//   points coincide, the first multiply, the divide and the clamp are skipped.
//   Configuration: APB, register 0 (max_level) at byte address 0; write only while idle.
//   Reset: all slots are marked absent through per-slot valid bits, max_level = 255,
//   no clearing pass; the block takes transactions in the first cycle after reset.
module scheduled_dimming_interpolator #(
    parameter int POINTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sdi_pkg::sdi_item_t  item,
    output logic                done,
    output sdi_pkg::sdi_result_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import sdi_pkg::*;

    localparam int AW = $clog2(POINTS);
    localparam int CW = $clog2(POINTS + 1);

    sdi_state_t state_reg, state_next;
    logic [CW-1:0]     ctr_reg, ctr_next;
    logic [POINTS-1:0] valid_reg, valid_next;
    logic [7:0]        max_level_reg;
    logic              done_reg, done_next;
    sdi_result_t       result_reg, result_next;

    sdi_item_t         item_reg, item_next;
    logic [HALF_W-1:0] cur_reg, cur_next;
    logic [HALF_W-1:0] last_reg, last_next;
    sdi_point_t        pt0_reg, pt0_next;
    sdi_point_t        prev_reg, prev_next;
    sdi_point_t        nxt_reg, nxt_next;
    logic [SEC_W-1:0]  t1_reg, t1_next;
    logic [WRAP_W-1:0] t2_reg, t2_next;
    logic [WRAP_W-1:0] tn_reg, tn_next;
    logic [DIV_D_W-1:0] span_reg, span_next;
    logic              neg_reg, neg_next;
    logic [7:0]        lvl_reg, lvl_next;

    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    sdi_point_t        ram_wdata;
    sdi_point_t        ent;
    logic [HALF_W-1:0] t_ent;
    logic [AW-1:0]     eidx;
    logic              hit;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start, div_done;
    logic [PROD_W-1:0]  div_quot;

    logic [WRAP_W:0]    dt;
    logic [WRAP_W:0]    span_s;
    logic [WRAP_W-1:0]  t2_adj;
    logic [8:0]         dy;
    logic [PROD_W:0]    sum;
    logic [HALF_W:0]    dq;
    logic               cfg_write;

    sdi_ram #(
        .WIDTH ($bits(sdi_point_t)),
        .DEPTH (POINTS)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.point_index)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ent)
    );

    sdi_serial_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    sdi_serial_div #(
        .N_W (PROD_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign ram_wdata = '{hour: item.point_hour, minute: item.point_minute,
                         level: item.point_level};
    assign ram_raddr = (state_reg == ST_SCAN) ? ctr_reg[AW-1:0] : '0;
    assign t_ent     = sdi_half_of(ent.hour, ent.minute);
    assign eidx      = AW'(ctr_reg - CW'(1));

    always_comb
    begin
        state_next  = state_reg;
        ctr_next    = ctr_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        item_next   = item_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        pt0_next    = pt0_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        tn_next     = tn_reg;
        span_next   = span_reg;
        neg_next    = neg_reg;
        lvl_next    = lvl_reg;
        ram_we      = 1'b0;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        hit         = 1'b0;
        dt          = '0;
        span_s      = '0;
        t2_adj      = '0;
        dy          = '0;
        sum         = '0;
        dq          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.req_type == REQ_WRITE)
                    begin
                        if (32'(item.point_index) < POINTS)
                        begin
                            ram_we = 1'b1;
                            valid_next[AW'(item.point_index)] = item.point_present;
                        end
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else if (!valid_reg[0])
                    begin
                        result_next = '{level: 8'd0, duty: 8'd0, supply_off: 1'b1};
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        item_next  = item;
                        cur_next   = sdi_half_of(item.query_hour, item.query_minute)
                                   + HALF_W'(item.query_second[5:1]) + HALF_W'(1);
                        ctr_next   = CW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ctr_reg == CW'(1))
                begin
                    last_next = t_ent;
                    prev_next = ent;
                    pt0_next  = ent;
                end
                else if (valid_reg[eidx])
                begin
                    if (cur_reg > last_reg && cur_reg <= t_ent)
                    begin
                        hit        = 1'b1;
                        nxt_next   = ent;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        last_next = t_ent;
                        prev_next = ent;
                    end
                end
                if (!hit)
                begin
                    if (ctr_reg == CW'(POINTS))
                    begin
                        nxt_next   = pt0_reg;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        ctr_next = ctr_reg + CW'(1);
                    end
                end
            end

            ST_PREP:
            begin
                t1_next    = sdi_sec_of(prev_reg.hour, prev_reg.minute);
                t2_next    = WRAP_W'(sdi_sec_of(nxt_reg.hour, nxt_reg.minute));
                tn_next    = WRAP_W'(sdi_sec_of(item_reg.query_hour, item_reg.query_minute))
                           + WRAP_W'(item_reg.query_second);
                state_next = ST_ADJ;
            end

            ST_ADJ:
            begin
                t2_adj = (t2_reg < WRAP_W'(t1_reg)) ? t2_reg + DAY_SECONDS : t2_reg;
                if (t2_adj == WRAP_W'(t1_reg))
                begin
                    lvl_next   = nxt_reg.level;
                    state_next = ST_LVL;
                end
                else
                begin
                    t2_next = t2_adj;
                    if (tn_reg < WRAP_W'(t1_reg))
                    begin
                        tn_next = tn_reg + DAY_SECONDS;
                    end
                    state_next = ST_DIFF;
                end
            end

            ST_DIFF:
            begin
                dt        = {1'b0, tn_reg} - (WRAP_W + 1)'(t1_reg);
                dy        = {1'b0, nxt_reg.level} - {1'b0, prev_reg.level};
                // span is positive here, since ST_ADJ already wrapped t2 above t1
                span_s    = {1'b0, t2_reg} - (WRAP_W + 1)'(t1_reg);
                span_next = span_s[WRAP_W] ? DIV_D_W'(-span_s) : DIV_D_W'(span_s);
                neg_next  = dt[WRAP_W] ^ dy[8] ^ span_s[WRAP_W];
                mul_a     = dt[WRAP_W] ? MUL_A_W'(-dt) : MUL_A_W'(dt);
                mul_b     = dy[8] ? MUL_B_W'(-dy) : MUL_B_W'(dy);
                mul_start = 1'b1;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CLAMP;
                end
            end

            ST_CLAMP:
            begin
                if (neg_reg)
                begin
                    if (div_quot >= PROD_W'(prev_reg.level))
                    begin
                        lvl_next = 8'd0;
                    end
                    else
                    begin
                        lvl_next = prev_reg.level - div_quot[7:0];
                    end
                end
                else
                begin
                    sum = (PROD_W + 1)'(div_quot) + (PROD_W + 1)'(prev_reg.level);
                    if (sum > (PROD_W + 1)'(LEVEL_TOP))
                    begin
                        lvl_next = LEVEL_TOP;
                    end
                    else
                    begin
                        lvl_next = sum[7:0];
                    end
                end
                state_next = ST_LVL;
            end

            ST_LVL:
            begin
                mul_a      = MUL_A_W'(max_level_reg);
                mul_b      = lvl_reg;
                mul_start  = 1'b1;
                state_next = ST_DMUL;
            end

            ST_DMUL:
            begin
                if (mul_done)
                begin
                    // x/255 as (x + x/256 + 1)/256, exact below 65535
                    dq = (HALF_W + 1)'(mul_prod[HALF_W-1:0])
                       + (HALF_W + 1)'(mul_prod[HALF_W-1:8]) + (HALF_W + 1)'(1);
                    result_next = '{level: lvl_reg, duty: dq[15:8],
                                    supply_off: (lvl_reg == 8'd0)};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctr_reg   <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        last_reg   <= last_next;
        pt0_reg    <= pt0_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        tn_reg     <= tn_next;
        span_reg   <= span_next;
        neg_reg    <= neg_next;
        lvl_reg    <= lvl_next;
    end

    // config port
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_LEVEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= MAX_LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            max_level_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_LEVEL) ? {24'd0, max_level_reg} : '0;
    assign pready = 1'b1;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
